// ----- rtl/utcep_pkg.sv -----
// utcep_pkg: shared types, constants and the day-of-year table for the
// UTC date/time to epoch converter. No dependencies.
package utcep_pkg;

    localparam int unsigned FIELD_W   = 7;
    localparam int unsigned YEAR_W    = 12;
    localparam int unsigned SECS_W    = 32;
    localparam int unsigned DAYS_W    = 16;
    localparam int unsigned DOE_W     = 18;
    localparam int unsigned ERA_SUM_W = 21;
    localparam int unsigned TOD_W     = 17;

    localparam logic [FIELD_W-1:0]   YEAR_PIVOT   = 7'd80;
    localparam logic [FIELD_W-1:0]   YY_MAX       = 7'd99;
    localparam logic [YEAR_W-1:0]    CENTURY_19   = 12'd1900;
    localparam logic [YEAR_W-1:0]    CENTURY_20   = 12'd2000;
    localparam logic [YEAR_W-1:0]    MIN_YEAR     = 12'd1980;
    localparam logic [YEAR_W-1:0]    ERA5_START   = 12'd2000;
    localparam logic [YEAR_W-1:0]    ERA4_START   = 12'd1600;
    localparam logic [ERA_SUM_W-1:0] ERA4_DAYS    = 21'd584388;   // 4 * 146097
    localparam logic [ERA_SUM_W-1:0] ERA5_DAYS    = 21'd730485;   // 5 * 146097
    localparam logic [ERA_SUM_W-1:0] EPOCH_OFFSET = 21'd719468;
    localparam logic [SECS_W:0]      SECS_PER_DAY = 33'd86400;
    localparam logic [TOD_W-1:0]     SECS_PER_HR  = 17'd3600;
    localparam logic [TOD_W-1:0]     SECS_PER_MIN = 17'd60;

    typedef struct packed {
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] yy;
    } fix_word_t;

    typedef struct packed {
        logic [YEAR_W-1:0] full_year;
        logic              time_ok;
        logic              date_ok;
        logic              epoch_ok;
        logic [SECS_W-1:0] unix_seconds;
    } epoch_word_t;

    // (153 * mp + 2) / 5, days before shifted month mp (March = 0)
    function automatic logic [8:0] month_start_day(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/utcep_calc.sv -----
// utcep_calc: combinational range checks, century pivot and civil-day to
// epoch-seconds conversion for one fix word. Depends on utcep_pkg.
module utcep_calc (
    input  utcep_pkg::fix_word_t   fix,
    output utcep_pkg::epoch_word_t res
);

    logic [utcep_pkg::YEAR_W-1:0]    year;
    logic                            t_ok;
    logic                            d_ok;
    logic                            m_le2;
    logic [utcep_pkg::YEAR_W-1:0]    y;
    logic                            era5;
    logic [8:0]                      yoe;
    logic [utcep_pkg::FIELD_W-1:0]   mp_wide;
    logic [1:0]                      yoe_cent;
    logic [utcep_pkg::DOE_W-1:0]     doe;
    logic [utcep_pkg::ERA_SUM_W-1:0] day_sum;
    logic [utcep_pkg::DAYS_W-1:0]    days;
    logic [utcep_pkg::TOD_W-1:0]     tod;
    logic [utcep_pkg::SECS_W:0]      day_secs;
    logic [utcep_pkg::SECS_W-1:0]    secs;

    always_comb
    begin
        year = (fix.yy >= utcep_pkg::YEAR_PIVOT)
             ? utcep_pkg::CENTURY_19 + 12'(fix.yy)
             : utcep_pkg::CENTURY_20 + 12'(fix.yy);

        t_ok = (fix.hour < 7'd24) && (fix.minute < 7'd60) && (fix.second < 7'd60);
        d_ok = (fix.yy <= utcep_pkg::YY_MAX) && (year >= utcep_pkg::MIN_YEAR)
            && (fix.month >= 7'd1) && (fix.month <= 7'd12)
            && (fix.day >= 7'd1) && (fix.day <= 7'd31);

        m_le2 = (fix.month <= 7'd2);
        y     = year - 12'(m_le2);
        era5  = (y >= utcep_pkg::ERA5_START);
        yoe   = era5 ? 9'(y - utcep_pkg::ERA5_START) : 9'(y - utcep_pkg::ERA4_START);

        mp_wide = m_le2 ? fix.month + 7'd9 : fix.month - 7'd3;

        if (yoe >= 9'd300)
            yoe_cent = 2'd3;
        else if (yoe >= 9'd200)
            yoe_cent = 2'd2;
        else if (yoe >= 9'd100)
            yoe_cent = 2'd1;
        else
            yoe_cent = 2'd0;

        doe = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(yoe_cent)
            + 18'(utcep_pkg::month_start_day(mp_wide[3:0])) + 18'(fix.day) - 18'd1;

        day_sum = (era5 ? utcep_pkg::ERA5_DAYS : utcep_pkg::ERA4_DAYS)
                + 21'(doe) - utcep_pkg::EPOCH_OFFSET;
        days    = day_sum[utcep_pkg::DAYS_W-1:0];

        tod = 17'(fix.hour) * utcep_pkg::SECS_PER_HR
            + 17'(fix.minute) * utcep_pkg::SECS_PER_MIN + 17'(fix.second);

        day_secs = 33'(days) * utcep_pkg::SECS_PER_DAY;
        secs     = day_secs[utcep_pkg::SECS_W-1:0] + 32'(tod);

        res.full_year    = year;
        res.time_ok      = t_ok;
        res.date_ok      = d_ok;
        res.epoch_ok     = t_ok && d_ok;
        res.unix_seconds = (t_ok && d_ok) ? secs : '0;
    end

endmodule

// ----- rtl/utc_date_time_to_epoch.sv -----
// utc_date_time_to_epoch: top level; input word register, conversion, result
// register. Depends on utcep_pkg and utcep_calc.
// The input word register holds the accepted word; the result register and done then take its conversion.
// Throughput: one word per cycle; busy is always low.
// Reset: rst_n clears the input valid bit and done; payload is not reset.
module utc_date_time_to_epoch (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [utcep_pkg::FIELD_W-1:0] hour_in,
    input  logic [utcep_pkg::FIELD_W-1:0] minute_in,
    input  logic [utcep_pkg::FIELD_W-1:0] second_in,
    input  logic [utcep_pkg::FIELD_W-1:0] day_in,
    input  logic [utcep_pkg::FIELD_W-1:0] month_in,
    input  logic [utcep_pkg::FIELD_W-1:0] year_two_digit,
    output logic                          done,
    output logic [utcep_pkg::YEAR_W-1:0]  full_year,
    output logic                          time_ok,
    output logic                          date_ok,
    output logic                          epoch_ok,
    output logic [utcep_pkg::SECS_W-1:0]  unix_seconds
);

    utcep_pkg::fix_word_t   fix_reg;
    utcep_pkg::epoch_word_t res_next;
    utcep_pkg::epoch_word_t res_reg;
    logic                   fix_vld_reg;
    logic                   done_reg;
    logic                   accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            fix_vld_reg <= accept;
            done_reg    <= fix_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fix_reg.hour   <= hour_in;
            fix_reg.minute <= minute_in;
            fix_reg.second <= second_in;
            fix_reg.day    <= day_in;
            fix_reg.month  <= month_in;
            fix_reg.yy     <= year_two_digit;
        end
        if (fix_vld_reg)
            res_reg <= res_next;
    end

    utcep_calc u_calc (
        .fix (fix_reg),
        .res (res_next)
    );

    assign done         = done_reg;
    assign full_year    = res_reg.full_year;
    assign time_ok      = res_reg.time_ok;
    assign date_ok      = res_reg.date_ok;
    assign epoch_ok     = res_reg.epoch_ok;
    assign unix_seconds = res_reg.unix_seconds;

endmodule

// ----- rtl/utcep_checker.sv -----
// utcep_checker: port-level assertions for utc_date_time_to_epoch, bound to
// the top level. Depends on utcep_pkg.
module utcep_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [utcep_pkg::FIELD_W-1:0] hour_in,
    input logic [utcep_pkg::FIELD_W-1:0] minute_in,
    input logic [utcep_pkg::FIELD_W-1:0] second_in,
    input logic [utcep_pkg::FIELD_W-1:0] day_in,
    input logic [utcep_pkg::FIELD_W-1:0] month_in,
    input logic [utcep_pkg::FIELD_W-1:0] year_two_digit,
    input logic                          done,
    input logic [utcep_pkg::YEAR_W-1:0]  full_year,
    input logic                          time_ok,
    input logic                          date_ok,
    input logic                          epoch_ok,
    input logic [utcep_pkg::SECS_W-1:0]  unix_seconds
);

    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted word produced no result");

    a_done_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted word");

    a_epoch_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (epoch_ok == (time_ok && date_ok)))
        else $error("epoch_ok disagrees with time_ok and date_ok");

    a_epoch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !epoch_ok) |-> (unix_seconds == '0))
        else $error("unix_seconds nonzero on invalid fix");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && date_ok) |-> (full_year >= 12'd1980 && full_year <= 12'd2079))
        else $error("full_year out of range on valid date");

endmodule

bind utc_date_time_to_epoch utcep_checker u_utcep_checker (.*);

// ----- verif/utc_date_time_to_epoch_tb.sv -----
// utc_date_time_to_epoch_tb: self-checking bench for the UTC date/time to Unix epoch converter.
// Needs utcep_pkg and utc_date_time_to_epoch; a built-in calendar predictor checks every word.
module utc_date_time_to_epoch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_WORDS   = 700;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned TAIL_CYCLES    = 8;

    typedef struct {
        utcep_pkg::fix_word_t fix;
        int unsigned          gap;
        bit                   drain;
    } pending_word_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [utcep_pkg::FIELD_W-1:0]  hour_in = '0;
    logic [utcep_pkg::FIELD_W-1:0]  minute_in = '0;
    logic [utcep_pkg::FIELD_W-1:0]  second_in = '0;
    logic [utcep_pkg::FIELD_W-1:0]  day_in = '0;
    logic [utcep_pkg::FIELD_W-1:0]  month_in = '0;
    logic [utcep_pkg::FIELD_W-1:0]  year_two_digit = '0;
    logic                           done;
    logic [utcep_pkg::YEAR_W-1:0]   full_year;
    logic                           time_ok;
    logic                           date_ok;
    logic                           epoch_ok;
    logic [utcep_pkg::SECS_W-1:0]   unix_seconds;

    pending_word_t          pending_words[$];
    utcep_pkg::epoch_word_t expected_words[$];
    pending_word_t          cur;
    bit                     driving = 1'b0;
    bit                     took = 1'b0;
    bit                     no_gaps = 1'b0;
    int unsigned            gap_count = 0;
    int unsigned            idle_cycles = 0;
    int unsigned            errors = 0;
    int unsigned            words_in = 0;
    int unsigned            epochs_valid = 0;

    utc_date_time_to_epoch DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .hour_in        (hour_in),
        .minute_in      (minute_in),
        .second_in      (second_in),
        .day_in         (day_in),
        .month_in       (month_in),
        .year_two_digit (year_two_digit),
        .done           (done),
        .full_year      (full_year),
        .time_ok        (time_ok),
        .date_ok        (date_ok),
        .epoch_ok       (epoch_ok),
        .unix_seconds   (unix_seconds)
    );

    always #2 clk = ~clk;

    function automatic utcep_pkg::epoch_word_t convert_fix(utcep_pkg::fix_word_t f);
        utcep_pkg::epoch_word_t r;
        int unsigned     yr;
        int unsigned     y;
        int unsigned     era;
        int unsigned     yoe;
        int unsigned     mp;
        int unsigned     doy;
        int unsigned     doe;
        longint unsigned days;
        longint unsigned secs;
        yr = (f.yy >= utcep_pkg::YEAR_PIVOT) ? utcep_pkg::CENTURY_19 + f.yy
                                             : utcep_pkg::CENTURY_20 + f.yy;
        r.full_year = yr[utcep_pkg::YEAR_W-1:0];
        r.time_ok = f.hour < 24 && f.minute < 60 && f.second < 60;
        r.date_ok = f.yy <= utcep_pkg::YY_MAX && yr >= utcep_pkg::MIN_YEAR &&
                    f.month >= 1 && f.month <= 12 && f.day >= 1 && f.day <= 31;
        r.epoch_ok = r.time_ok && r.date_ok;
        secs = 0;
        if (r.epoch_ok)
        begin
            // March-based year so the leap day falls at the end
            y    = yr - ((f.month <= 2) ? 1 : 0);
            era  = y / 400;
            yoe  = y - era * 400;
            mp   = (f.month > 2) ? f.month - 3 : f.month + 9;
            doy  = (153 * mp + 2) / 5 + f.day - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = longint'(era) * 146097 + doe - 719468;
            secs = days * 86400 + longint'(f.hour) * 3600 + longint'(f.minute) * 60 + f.second;
        end
        r.unix_seconds = secs[utcep_pkg::SECS_W-1:0];
        return r;
    endfunction

    function automatic utcep_pkg::fix_word_t make_fix(int h, int mi, int s, int d, int mo,
                                                      int yy);
        utcep_pkg::fix_word_t f;
        f.hour   = h[utcep_pkg::FIELD_W-1:0];
        f.minute = mi[utcep_pkg::FIELD_W-1:0];
        f.second = s[utcep_pkg::FIELD_W-1:0];
        f.day    = d[utcep_pkg::FIELD_W-1:0];
        f.month  = mo[utcep_pkg::FIELD_W-1:0];
        f.yy     = yy[utcep_pkg::FIELD_W-1:0];
        return f;
    endfunction

    function automatic logic [utcep_pkg::FIELD_W-1:0] rand_field(int unsigned lo,
                                                                int unsigned hi);
        int unsigned v;
        v = $urandom_range(hi, lo);
        return v[utcep_pkg::FIELD_W-1:0];
    endfunction

    task automatic queue_word(utcep_pkg::fix_word_t f, bit drain);
        pending_word_t p;
        if ($urandom_range(0, 39) == 0)
            no_gaps = !no_gaps;
        p.fix   = f;
        p.gap   = no_gaps ? 0 : $urandom_range(0, 19);
        p.drain = drain;
        pending_words.push_back(p);
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // driver: presents the next word after its gap, holds it until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (driving && took)
                driving = 1'b0;
            if (!driving && pending_words.size() > 0)
            begin
                if (gap_count < pending_words[0].gap)
                    gap_count++;
                else if (!pending_words[0].drain || expected_words.size() == 0)
                begin
                    cur = pending_words.pop_front();
                    driving = 1'b1;
                    gap_count = 0;
                    hour_in        <= cur.fix.hour;
                    minute_in      <= cur.fix.minute;
                    second_in      <= cur.fix.second;
                    day_in         <= cur.fix.day;
                    month_in       <= cur.fix.month;
                    year_two_digit <= cur.fix.yy;
                end
            end
            start <= driving;
        end
    end

    // monitor: checks results, predicts on every accepted word
    always @(posedge clk)
    begin : monitor
        utcep_pkg::epoch_word_t got;
        utcep_pkg::epoch_word_t want;
        utcep_pkg::fix_word_t   f;
        bit                     taken_now;
        if (rst_n)
        begin
            taken_now = start && !busy;
            if (done)
            begin
                got = '{full_year, time_ok, date_ok, epoch_ok, unix_seconds};
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual year %0d epoch %0d",
                             $time, got.full_year, got.unix_seconds);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("full_year", 64'(want.full_year), 64'(got.full_year));
                    check_field("time_ok", 64'(want.time_ok), 64'(got.time_ok));
                    check_field("date_ok", 64'(want.date_ok), 64'(got.date_ok));
                    check_field("epoch_ok", 64'(want.epoch_ok), 64'(got.epoch_ok));
                    check_field("unix_seconds", 64'(want.unix_seconds),
                                64'(got.unix_seconds));
                end
            end
            if (taken_now)
            begin
                f = '{hour_in, minute_in, second_in, day_in, month_in, year_two_digit};
                want = convert_fix(f);
                expected_words.push_back(want);
                words_in++;
                if (want.epoch_ok)
                    epochs_valid++;
            end
            took <= taken_now;
            if (taken_now || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, expected_words.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        utcep_pkg::fix_word_t f;
        int unsigned          pick;
        // directed corners
        queue_word(make_fix(0, 0, 0, 1, 1, 80), 1'b0);       // earliest valid, 1980-01-01
        queue_word(make_fix(23, 59, 59, 31, 12, 79), 1'b0);  // latest valid, 2079-12-31
        queue_word(make_fix(0, 0, 0, 0, 0, 0), 1'b0);
        queue_word(make_fix(127, 127, 127, 127, 127, 127), 1'b0);
        queue_word(make_fix(12, 0, 0, 29, 2, 0), 1'b0);      // leap day 2000
        queue_word(make_fix(0, 0, 0, 31, 2, 1), 1'b0);       // Feb 31 rolls into March
        queue_word(make_fix(23, 59, 59, 31, 12, 99), 1'b0);
        queue_word(make_fix(0, 0, 0, 1, 1, 0), 1'b0);
        queue_word(make_fix(6, 30, 15, 15, 6, 100), 1'b0);   // year beyond two digits
        queue_word(make_fix(6, 30, 15, 15, 6, 127), 1'b0);
        queue_word(make_fix(24, 0, 0, 1, 1, 10), 1'b0);
        queue_word(make_fix(0, 60, 0, 1, 1, 10), 1'b0);
        queue_word(make_fix(0, 0, 60, 1, 1, 10), 1'b0);
        queue_word(make_fix(1, 2, 3, 1, 0, 10), 1'b0);
        queue_word(make_fix(1, 2, 3, 1, 13, 10), 1'b0);
        queue_word(make_fix(1, 2, 3, 0, 5, 10), 1'b0);
        queue_word(make_fix(1, 2, 3, 32, 5, 10), 1'b0);
        queue_word(make_fix(23, 59, 59, 28, 2, 24), 1'b0);
        queue_word(make_fix(0, 0, 0, 1, 3, 24), 1'b0);
        queue_word(make_fix(24, 60, 60, 0, 13, 100), 1'b1);
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            f = make_fix($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                         $urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(0, 99));
            pick = $urandom_range(0, 99);
            if (pick >= 85)
                f = make_fix($urandom_range(0, 127), $urandom_range(0, 127),
                             $urandom_range(0, 127), $urandom_range(0, 127),
                             $urandom_range(0, 127), $urandom_range(0, 127));
            else if (pick >= 70)
            begin
                case ($urandom_range(0, 5))
                    0: f.hour   = rand_field(24, 127);
                    1: f.minute = rand_field(60, 127);
                    2: f.second = rand_field(60, 127);
                    3: f.day    = ($urandom_range(0, 1) == 0) ? '0 : rand_field(32, 127);
                    4: f.month  = ($urandom_range(0, 1) == 0) ? '0 : rand_field(13, 127);
                    default: f.yy = rand_field(100, 127);
                endcase
            end
            queue_word(f, (i % 150) == 149);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || driving || expected_words.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d date/time words: %0d gave an epoch, %0d were rejected",
                 words_in, epochs_valid, words_in - epochs_valid);
        if (errors == 0 && expected_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/utcep_pkg.sv
rtl/utcep_calc.sv
rtl/utc_date_time_to_epoch.sv
rtl/utcep_checker.sv
verif/utc_date_time_to_epoch_tb.sv
